>>> src/pidr_pkg.sv
// Shared types and constants for the PID position regulator.
// No dependencies; imported by pidr_err_stage and pid_position_regulator.
package pidr_pkg;

  localparam int SAMPLE_WIDTH = 24;
  localparam int TERM_W       = SAMPLE_WIDTH + 1;  // integral and derivative
  localparam int GAIN_W       = 24;
  localparam int LIMIT_W      = SAMPLE_WIDTH - 1;
  localparam int SPEED_W      = 15;
  localparam int DRIVE_W      = 16;
  localparam int PROD_W       = 2 * TERM_W;
  localparam int SUM_W        = PROD_W + 2;
  localparam int FRAC_W       = 16;               // gain fraction bits
  localparam int ADDR_W       = 5;

  // Register indexes (paddr[4:2])
  localparam logic [2:0] REG_GAIN_P    = 3'd0;
  localparam logic [2:0] REG_GAIN_I    = 3'd1;
  localparam logic [2:0] REG_GAIN_D    = 3'd2;
  localparam logic [2:0] REG_INT_LIMIT = 3'd3;
  localparam logic [2:0] REG_TOLERANCE = 3'd4;
  localparam logic [2:0] REG_SPEED_MAX = 3'd5;
  localparam logic [2:0] REG_SPEED_MIN = 3'd6;
  localparam logic [2:0] REG_SETPOINT  = 3'd7;

  localparam logic [SPEED_W-1:0] SPEED_MAX_RESET = 15'd25600;

  typedef struct packed {
    logic                           start_req;
    logic signed [SAMPLE_WIDTH-1:0] measured;
  } sample_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      done_res;
  } result_t;

  // Per-sample terms handed from the error stage to the multipliers
  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] err;
    logic signed [TERM_W-1:0]       integ;
    logic signed [TERM_W-1:0]       deriv;
    logic                           done;
  } terms_t;

endpackage

>>> src/pidr_err_stage.sv
// Error, clamped integral and derivative stage; owns the regulator state.
// Depends on pidr_pkg.
module pidr_err_stage (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   step,
  input  pidr_pkg::sample_t                      sample,
  input  logic signed [pidr_pkg::SAMPLE_WIDTH-1:0] setpoint,
  input  logic [pidr_pkg::LIMIT_W-1:0]           integral_limit,
  input  logic [pidr_pkg::LIMIT_W-1:0]           tolerance,
  output pidr_pkg::terms_t                       terms
);
  import pidr_pkg::*;

  logic signed [TERM_W-1:0]       integral_sum;
  logic signed [TERM_W-1:0]       integral_sum_next;
  logic signed [SAMPLE_WIDTH-1:0] previous_error;

  logic signed [SAMPLE_WIDTH:0]   diff;
  logic signed [SAMPLE_WIDTH-1:0] err;
  logic signed [SAMPLE_WIDTH-1:0] prev_eff;
  logic signed [TERM_W-1:0]       integ_eff;
  logic signed [TERM_W:0]         isum;
  logic signed [TERM_W:0]         lim_pos;
  logic signed [TERM_W:0]         lim_neg;
  logic signed [TERM_W-1:0]       deriv;
  logic [SAMPLE_WIDTH-1:0]        emag;

  always_comb begin
    diff = {setpoint[SAMPLE_WIDTH-1], setpoint}
         - {sample.measured[SAMPLE_WIDTH-1], sample.measured};
    // saturate to the sample range
    if (diff[SAMPLE_WIDTH] != diff[SAMPLE_WIDTH-1]) begin
      err = diff[SAMPLE_WIDTH] ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
                               : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end else begin
      err = diff[SAMPLE_WIDTH-1:0];
    end

    // a start request begins from a clean integral and error history
    prev_eff  = sample.start_req ? setpoint : previous_error;
    integ_eff = sample.start_req ? '0 : integral_sum;

    isum    = {integ_eff[TERM_W-1], integ_eff}
            + {{(TERM_W+1-SAMPLE_WIDTH){err[SAMPLE_WIDTH-1]}}, err};
    lim_pos = {{(TERM_W+1-LIMIT_W){1'b0}}, integral_limit};
    lim_neg = -lim_pos;
    if (isum > lim_pos) begin
      integral_sum_next = lim_pos[TERM_W-1:0];
    end else if (isum < lim_neg) begin
      integral_sum_next = lim_neg[TERM_W-1:0];
    end else begin
      integral_sum_next = isum[TERM_W-1:0];
    end

    deriv = {err[SAMPLE_WIDTH-1], err} - {prev_eff[SAMPLE_WIDTH-1], prev_eff};
    emag  = err[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-err) : err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum   <= '0;
      previous_error <= '0;
    end else if (step) begin
      integral_sum   <= integral_sum_next;
      previous_error <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      terms.err   <= err;
      terms.integ <= integral_sum_next;
      terms.deriv <= deriv;
      terms.done  <= (emag <= {1'b0, tolerance});
    end
  end

endmodule

>>> src/pid_position_regulator.sv
// Top level of the PID position regulator: APB register file, pipeline
// control, gain multipliers and drive shaping. Depends on pidr_pkg, pidr_err_stage.
//
// Usage:
//  - sample channel (sample_valid/sample_ready, payload sample): one measured
//    position per transfer; start_req=1 clears the integral and loads the
//    previous error with the setpoint before that sample is used.
//  - result channel (result_valid/result_ready, payload result): exactly one
//    drive/done_res transfer per sample, in order.
//  - APB port: eight 32-bit registers at 4*index; writes land on the access
//    cycle, pready is tied high, reads return the stored value. Write only
//    while the pipeline is empty.
//  - Pipeline: input register -> error/integral stage (state update) ->
//    product register -> result register. Throughput is one sample per
//    cycle while result_ready holds high; the integral/previous-error loop
//    closes in the error stage alone.
//  - Stall: each stage holds when the one after it is full and not moving,
//    so up to four samples sit in flight; sample_ready drops only when all
//    four are occupied and result_ready is low.
//  - Reset (rst, synchronous): pipeline empties, integral and previous error
//    clear, registers go to zero except speed_max (25600).
module pid_position_regulator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  output logic                          sample_ready,
  input  pidr_pkg::sample_t             sample,
  output logic                          result_valid,
  input  logic                          result_ready,
  output pidr_pkg::result_t             result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pidr_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import pidr_pkg::*;

  // ---------------- configuration registers ----------------
  logic [GAIN_W-1:0]              gain_p, gain_i, gain_d;
  logic [LIMIT_W-1:0]             integral_limit, tolerance;
  logic [SPEED_W-1:0]             speed_max, speed_min;
  logic signed [SAMPLE_WIDTH-1:0] setpoint;
  logic [2:0]                     reg_idx;
  logic                           wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p         <= '0;
      gain_i         <= '0;
      gain_d         <= '0;
      integral_limit <= '0;
      tolerance      <= '0;
      speed_max      <= SPEED_MAX_RESET;
      speed_min      <= '0;
      setpoint       <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_GAIN_P:    gain_p         <= pwdata[GAIN_W-1:0];
        REG_GAIN_I:    gain_i         <= pwdata[GAIN_W-1:0];
        REG_GAIN_D:    gain_d         <= pwdata[GAIN_W-1:0];
        REG_INT_LIMIT: integral_limit <= pwdata[LIMIT_W-1:0];
        REG_TOLERANCE: tolerance      <= pwdata[LIMIT_W-1:0];
        REG_SPEED_MAX: speed_max      <= pwdata[SPEED_W-1:0];
        REG_SPEED_MIN: speed_min      <= pwdata[SPEED_W-1:0];
        REG_SETPOINT:  setpoint       <= pwdata[SAMPLE_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GAIN_P:    prdata = 32'(gain_p);
      REG_GAIN_I:    prdata = 32'(gain_i);
      REG_GAIN_D:    prdata = 32'(gain_d);
      REG_INT_LIMIT: prdata = 32'(integral_limit);
      REG_TOLERANCE: prdata = 32'(tolerance);
      REG_SPEED_MAX: prdata = 32'(speed_max);
      REG_SPEED_MIN: prdata = 32'(speed_min);
      REG_SETPOINT:  prdata = 32'($unsigned(setpoint));
      default:       prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  // v0: input register, v1: terms, v2: products, result_valid: output register
  logic v0, v1, v2;
  logic adv_o, adv2, adv1, adv0;

  assign adv_o        = !result_valid || result_ready;
  assign adv2         = !v2 || adv_o;
  assign adv1         = !v1 || adv2;
  assign adv0         = !v0 || adv1;
  assign sample_ready = adv0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0           <= 1'b0;
      v1           <= 1'b0;
      v2           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (adv0)  v0           <= sample_valid;
      if (adv1)  v1           <= v0;
      if (adv2)  v2           <= v1;
      if (adv_o) result_valid <= v2;
    end
  end

  // ---------------- input register ----------------
  sample_t sample_q;

  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) sample_q <= sample;
  end

  // ---------------- error / integral / derivative ----------------
  terms_t terms;

  pidr_err_stage u_err (
    .clk            (clk),
    .rst            (rst),
    .step           (v0 && adv1),
    .sample         (sample_q),
    .setpoint       (setpoint),
    .integral_limit (integral_limit),
    .tolerance      (tolerance),
    .terms          (terms)
  );

  // ---------------- gain products ----------------
  logic signed [PROD_W-1:0] prod_p, prod_i, prod_d;
  logic                     done_q;

  always_ff @(posedge clk) begin
    if (v1 && adv2) begin
      prod_p <= PROD_W'($signed({1'b0, gain_p})
                * $signed({terms.err[SAMPLE_WIDTH-1], terms.err}));
      prod_i <= PROD_W'($signed({1'b0, gain_i}) * terms.integ);
      prod_d <= PROD_W'($signed({1'b0, gain_d}) * terms.deriv);
      done_q <= terms.done;
    end
  end

  // ---------------- sum, limit, round ----------------
  logic signed [SUM_W-1:0] sum;
  logic [SUM_W-1:0]        mag;
  logic [SUM_W-1:0]        rnd;
  logic [SUM_W-1:0]        max_scaled, min_scaled;
  logic                    neg;
  logic [DRIVE_W-1:0]      drv_mag;
  logic signed [DRIVE_W-1:0] drive_next;

  always_comb begin
    sum = {{2{prod_p[PROD_W-1]}}, prod_p}
        + {{2{prod_i[PROD_W-1]}}, prod_i}
        + {{2{prod_d[PROD_W-1]}}, prod_d};
    neg        = sum[SUM_W-1];
    mag        = neg ? SUM_W'(-sum) : sum;
    max_scaled = SUM_W'({speed_max, {FRAC_W{1'b0}}});
    min_scaled = SUM_W'({speed_min, {FRAC_W{1'b0}}});
    // round half away from zero on the magnitude
    rnd        = mag + SUM_W'(1 << (FRAC_W - 1));
    if (sum == '0) begin
      drv_mag = '0;
    end else if (mag > max_scaled) begin
      drv_mag = DRIVE_W'(speed_max);
    end else if (mag < min_scaled) begin
      drv_mag = DRIVE_W'(speed_min);
    end else begin
      drv_mag = rnd[FRAC_W +: DRIVE_W];
    end
    drive_next = neg ? $signed(-drv_mag) : $signed(drv_mag);
  end

  always_ff @(posedge clk) begin
    if (v2 && adv_o) begin
      result.drive    <= drive_next;
      result.done_res <= done_q;
    end
  end

  // ---------------- assertions ----------------
  // Input stalls only when every stage holds an item.
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !sample_ready |-> (v0 && v1 && v2 && result_valid))
    else $error("sample_ready low with a free pipeline stage");

  // An item leaving the error stage lands in the product stage.
  a_terms_flow: assert property (@(posedge clk) disable iff (rst)
    (v1 && adv2) |=> v2)
    else $error("item lost between terms and products");

  // A held product stage keeps its item while the output is blocked.
  a_prod_hold: assert property (@(posedge clk) disable iff (rst)
    (v2 && !adv_o) |=> (v2 && $stable(prod_p) && $stable(prod_i) && $stable(prod_d)))
    else $error("product stage changed while stalled");

endmodule
